/* rtl/rbsi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, defaults and types of the ray/box slab interval block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int T_WIDTH = 31;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_WIDTH_DEF = 32;

	typedef struct packed {
		logic [2:0] zero;
		logic [2:0] neg0;
		logic [2:0] neg1;
		logic [2:0] bok;
	} sb_t;

	typedef struct packed {
		logic               hit;
		logic [T_WIDTH-1:0] t_enter;
		logic [T_WIDTH-1:0] t_exit;
	} res_t;

endpackage

/* rtl/rbsi_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_ray_if / rbsi_res_if
// Valid/ready channels for the ray and box beat and for the result beat.
// ----------------------------------------------------------------------------
interface rbsi_ray_if #(
	parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] origin_x, origin_y, origin_z;
	logic signed [COORD_WIDTH-1:0] dir_x, dir_y, dir_z;
	logic signed [COORD_WIDTH-1:0] lo_x, lo_y, lo_z;
	logic signed [COORD_WIDTH-1:0] hi_x, hi_y, hi_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface rbsi_res_if;
	logic valid;
	logic ready;
	logic hit;
	logic [rbsi_pkg::T_WIDTH-1:0] t_enter;
	logic [rbsi_pkg::T_WIDTH-1:0] t_exit;

	modport source (output valid, hit, t_enter, t_exit, input ready);
	modport sink (input valid, hit, t_enter, t_exit, output ready);
endinterface

/* rtl/rbsi_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider: one quotient bit per stage, saturating
// quotient of (num * 2^FRAC_BITS) / den; the stages advance only while en is high.
// ----------------------------------------------------------------------------
module rbsi_div #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [COORD_WIDTH:0]         num,
	input  logic [COORD_WIDTH-1:0]       den,
	output logic [rbsi_pkg::T_WIDTH-1:0] quo
);
	localparam int TW = rbsi_pkg::T_WIDTH;
	localparam int NW = COORD_WIDTH + 1 + FRAC_BITS;
	localparam int DW = COORD_WIDTH + TW;
	localparam int RW = (NW > DW) ? NW : DW;

	logic [RW-1:0]          rem_s [0:TW];
	logic [COORD_WIDTH-1:0] den_s [0:TW];
	logic [TW-1:0]          quo_s [0:TW];
	logic                   ovf_s [0:TW];
	logic [RW-1:0]          num_ext;

	assign num_ext = RW'({num, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_ext;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= num_ext >= (RW'(den) << TW);
		end
	end

	for (genvar k = 1; k <= TW; k++) begin : g_stage
		localparam int B = TW - k;
		logic [RW-1:0] sub;
		assign sub = RW'(den_s[k-1]) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				if (rem_s[k-1] >= sub) begin
					rem_s[k] <= rem_s[k-1] - sub;
					quo_s[k] <= quo_s[k-1] | (TW'(1) << B);
				end else begin
					rem_s[k] <= rem_s[k-1];
					quo_s[k] <= quo_s[k-1];
				end
			end
		end
	end

	assign quo = ovf_s[TW] ? {TW{1'b1}} : quo_s[TW];

endmodule

/* rtl/ray_box_slab_interval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_interval
// Beat path: stage-1, divider stages, stage-2, output register. A skid
// register holds one result while the output stalls; one beat per cycle is
// taken while it is empty. The divider retires one quotient bit per stage.
// Reset clears all valid bits and the output/skid registers; data is unreset.
// ----------------------------------------------------------------------------
module ray_box_slab_interval #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF,
	parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rbsi_ray_if.sink  ray,
	rbsi_res_if.source res
);
	localparam int TW = rbsi_pkg::T_WIDTH;
	localparam int L = TW + 1;
	localparam int CW = COORD_WIDTH;

	logic en;
	logic skid_v_q, out_v_q;
	rbsi_pkg::res_t skid_q, out_q, fin;

	assign en = !skid_v_q;
	assign ray.ready = en;

	logic signed [CW-1:0] o [3], d [3], l [3], h [3];
	assign o[0] = ray.origin_x; assign o[1] = ray.origin_y; assign o[2] = ray.origin_z;
	assign d[0] = ray.dir_x;    assign d[1] = ray.dir_y;    assign d[2] = ray.dir_z;
	assign l[0] = ray.lo_x;     assign l[1] = ray.lo_y;     assign l[2] = ray.lo_z;
	assign h[0] = ray.hi_x;     assign h[1] = ray.hi_y;     assign h[2] = ray.hi_z;

	logic [CW:0]   n0_s1 [3], n1_s1 [3];
	logic [CW-1:0] dd_s1 [3];
	rbsi_pkg::sb_t sb_s1;
	logic          v_s1;
	logic [TW-1:0] q0 [3], q1 [3];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [CW:0] df0, df1;
		assign df0 = {l[a][CW-1], l[a]} - {o[a][CW-1], o[a]};
		assign df1 = {h[a][CW-1], h[a]} - {o[a][CW-1], o[a]};
		always_ff @(posedge clk) begin
			if (en) begin
				n0_s1[a] <= df0[CW] ? (~df0 + 1'b1) : df0;
				n1_s1[a] <= df1[CW] ? (~df1 + 1'b1) : df1;
				dd_s1[a] <= d[a][CW-1] ? (~d[a] + 1'b1) : d[a];
				sb_s1.zero[a] <= (d[a] == '0);
				sb_s1.neg0[a] <= df0[CW] ^ d[a][CW-1];
				sb_s1.neg1[a] <= df1[CW] ^ d[a][CW-1];
				sb_s1.bok[a] <= (d[a] != '0) || ((o[a] >= l[a]) && (o[a] <= h[a]));
			end
		end
		rbsi_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_div0 (
			.clk(clk), .en(en),
			.num(n0_s1[a]), .den(dd_s1[a]), .quo(q0[a]));
		rbsi_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_div1 (
			.clk(clk), .en(en),
			.num(n1_s1[a]), .den(dd_s1[a]), .quo(q1[a]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray.valid;
		end
	end

	// sideband rides alongside the divider stages
	rbsi_pkg::sb_t sb_sd [0:L-1];
	logic          v_sd  [0:L-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sb_sd[0] <= sb_s1;
			for (int i = 1; i < L; i++) sb_sd[i] <= sb_sd[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L; i++) v_sd[i] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s1;
			for (int i = 1; i < L; i++) v_sd[i] <= v_sd[i-1];
		end
	end

	// signed, ordered slab distances
	logic signed [TW:0] lo_s2 [3], hi_s2 [3];
	logic [2:0]         mv_s2;
	logic               bok_s2, v_s2;

	for (genvar a = 0; a < 3; a++) begin : g_order
		logic signed [TW:0] t0, t1;
		assign t0 = sb_sd[L-1].neg0[a] ? -$signed({1'b0, q0[a]}) : $signed({1'b0, q0[a]});
		assign t1 = sb_sd[L-1].neg1[a] ? -$signed({1'b0, q1[a]}) : $signed({1'b0, q1[a]});
		always_ff @(posedge clk) begin
			if (en) begin
				lo_s2[a] <= (t0 > t1) ? t1 : t0;
				hi_s2[a] <= (t0 > t1) ? t0 : t1;
				mv_s2[a] <= !sb_sd[L-1].zero[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bok_s2 <= &sb_sd[L-1].bok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_sd[L-1];
		end
	end

	// narrow the interval over the three axes
	always_comb begin
		logic signed [TW:0] st, nd;
		st = '0;
		nd = $signed({1'b0, {TW{1'b1}}});
		for (int a = 0; a < 3; a++) begin
			if (mv_s2[a] && (lo_s2[a] > st)) st = lo_s2[a];
			if (mv_s2[a] && (hi_s2[a] < nd)) nd = hi_s2[a];
		end
		fin.hit = bok_s2 && (st <= nd);
		fin.t_enter = fin.hit ? st[TW-1:0] : '0;
		fin.t_exit = fin.hit ? nd[TW-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
			out_q <= '0;
			skid_q <= '0;
		end else if (!out_v_q || res.ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_q <= fin;
				out_v_q <= v_s2;
			end
		end else if (en && v_s2) begin
			skid_q <= fin;
			skid_v_q <= 1'b1;
		end
	end

	assign res.valid = out_v_q;
	assign res.hit = out_q.hit;
	assign res.t_enter = out_q.t_enter;
	assign res.t_exit = out_q.t_exit;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_q.hit) |-> (out_q.t_enter == '0 && out_q.t_exit == '0))
		else $error("miss beat carries nonzero distances");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.hit) |-> (out_q.t_enter <= out_q.t_exit))
		else $error("entry beyond exit on a hit");

	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a beat while output is empty");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !res.ready) |=> (out_v_q && $stable(out_q)))
		else $error("stalled result changed");

endmodule
